>>> sv/attl_pkg.sv
// ----------------------------------------------------------------------------
// attl_pkg: shared types and constants of the address track table
// Beat structures of both channels, the token that runs along the cell
// chain, the broadcast write port and the operation and register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package attl_pkg;

    localparam int SLOT_W  = 6;
    localparam int COUNT_W = 7;
    localparam int ADDR_W  = 48;
    localparam int TIME_W  = 32;
    localparam int RSSI_W  = 8;
    localparam int NUM_W   = 6;

    // Reset value of the age limit in milliseconds.
    localparam logic [TIME_W-1:0] STALE_RESET = 32'd15000;

    // Configuration register indexes.
    localparam logic CFG_ENABLE = 1'b0;
    localparam logic CFG_STALE  = 1'b1;

    // Operation codes; OP_NONE also stands for an observe while disabled.
    typedef enum logic [1:0] {
        OP_OBSERVE = 2'd0,
        OP_SWEEP   = 2'd1,
        OP_READ    = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]               operation;
        logic [ADDR_W-1:0]        device_address;
        logic signed [RSSI_W-1:0] signal_strength;
        logic [TIME_W-1:0]        now_time;
        logic [NUM_W-1:0]         entry_number;
    } t_in;

    typedef struct packed {
        logic                     accepted;
        logic                     found;
        logic                     allocated_new;
        logic                     evicted;
        logic [SLOT_W-1:0]        slot;
        logic [ADDR_W-1:0]        out_address;
        logic signed [RSSI_W-1:0] out_strength;
        logic [TIME_W-1:0]        out_time;
        logic [COUNT_W-1:0]       used_count;
    } t_out;

    // Token handed from cell to cell, one cell per cycle.
    typedef struct packed {
        logic                     valid;
        t_op                      op;
        logic [ADDR_W-1:0]        addr;
        logic signed [RSSI_W-1:0] rssi;
        logic [TIME_W-1:0]        now;
        logic [NUM_W-1:0]         want;
        logic [COUNT_W-1:0]       n;
        logic                     hit_found;
        logic [SLOT_W-1:0]        hit_idx;
        logic                     free_found;
        logic [SLOT_W-1:0]        free_idx;
        logic                     old_have;
        logic [TIME_W-1:0]        old_t;
        logic [SLOT_W-1:0]        old_idx;
        logic                     rd_found;
        logic [SLOT_W-1:0]        rd_idx;
        logic [ADDR_W-1:0]        rd_addr;
        logic signed [RSSI_W-1:0] rd_rssi;
        logic [TIME_W-1:0]        rd_time;
    } t_carry;

    // Write broadcast to all cells once an observe has chosen its slot.
    typedef struct packed {
        logic                     en;
        logic [SLOT_W-1:0]        slot;
        logic                     set_addr;
        logic [ADDR_W-1:0]        addr;
        logic signed [RSSI_W-1:0] rssi;
        logic [TIME_W-1:0]        now;
    } t_wr;

endpackage

`default_nettype wire

>>> sv/attl_cell.sv
// ----------------------------------------------------------------------------
// attl_cell: one table entry of the track chain
// Holds one entry and, when the token passes, updates the match, free,
// oldest and read search, ages the entry on a sweep and counts it as used.
// ----------------------------------------------------------------------------
`default_nettype none

module attl_cell #(
    parameter int CELL_INDEX = 0
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  attl_pkg::t_carry               i_carry,
    output attl_pkg::t_carry               o_carry,
    input  attl_pkg::t_wr                  i_wr,
    input  wire [attl_pkg::TIME_W-1:0]     i_stale_limit
);

    localparam logic [attl_pkg::SLOT_W-1:0] IDX = attl_pkg::SLOT_W'(CELL_INDEX);

    logic                               r_used;
    logic                               n_used;
    logic [attl_pkg::ADDR_W-1:0]        r_addr;
    logic signed [attl_pkg::RSSI_W-1:0] r_rssi;
    logic [attl_pkg::TIME_W-1:0]        r_time;
    attl_pkg::t_carry                   r_carry;
    attl_pkg::t_carry                   n_carry;
    logic [attl_pkg::TIME_W-1:0]        w_age;
    logic                               w_wr_here;

    assign w_age     = i_carry.now - r_time;
    assign w_wr_here = i_wr.en && (i_wr.slot == IDX);

    // Search and aging as the token passes this entry.
    always_comb begin
        n_carry = i_carry;
        n_used  = r_used;
        if (i_carry.valid) begin
            case (i_carry.op)
                attl_pkg::OP_OBSERVE: begin
                    if (!i_carry.hit_found) begin
                        if (!r_used) begin
                            if (!i_carry.free_found) begin
                                n_carry.free_found = 1'b1;
                                n_carry.free_idx   = IDX;
                            end
                        end else if (r_addr == i_carry.addr) begin
                            n_carry.hit_found = 1'b1;
                            n_carry.hit_idx   = IDX;
                        end else if (!i_carry.old_have || (r_time < i_carry.old_t)) begin
                            n_carry.old_have = 1'b1;
                            n_carry.old_t    = r_time;
                            n_carry.old_idx  = IDX;
                        end
                    end
                end
                attl_pkg::OP_SWEEP: begin
                    if (r_used && (w_age > i_stale_limit)) begin
                        n_used = 1'b0;
                    end
                end
                attl_pkg::OP_READ: begin
                    if (r_used && !i_carry.rd_found &&
                        (i_carry.n == {1'b0, i_carry.want})) begin
                        n_carry.rd_found = 1'b1;
                        n_carry.rd_idx   = IDX;
                        n_carry.rd_addr  = r_addr;
                        n_carry.rd_rssi  = r_rssi;
                        n_carry.rd_time  = r_time;
                    end
                end
                default: begin
                end
            endcase
            // Running count of used entries as they stand after this item.
            if (n_used) begin
                n_carry.n = i_carry.n + attl_pkg::COUNT_W'(1);
            end
        end else if (w_wr_here && i_wr.set_addr) begin
            n_used = 1'b1;
        end
    end

    // Entry storage; only the used flag and the token valid are reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry.valid <= 1'b0;
            r_used        <= 1'b0;
        end else begin
            r_carry <= n_carry;
            r_used  <= n_used;
        end
        if (w_wr_here) begin
            r_rssi <= i_wr.rssi;
            r_time <= i_wr.now;
            if (i_wr.set_addr) begin
                r_addr <= i_wr.addr;
            end
        end
    end

    assign o_carry = r_carry;

endmodule

`default_nettype wire

>>> sv/address_track_table_lru_top.sv
// ----------------------------------------------------------------------------
// address_track_table_lru_top: associative track table with LRU replacement
// A chain of entry cells is searched by a token that moves one cell a cycle.
// ----------------------------------------------------------------------------
// Use: items enter on the in channel (valid/ready) and each yields exactly
// one result beat on the out channel (valid/ready). An observe updates or
// allocates the entry of its address, a sweep frees stale entries and a read
// returns the n-th used entry. Configuration (enable, stale limit) is written
// through a plain write port while the block is idle.
// The token visits one cell per clock; an accepted item passes through the
// head register, each cell of the chain, the tail register and the output
// register. The table handles one item at a time; ready is high only
// between items.
// An output register holds the finished beat, so the next item is accepted
// while the result still waits; if the receiver stalls, the following item
// waits at the end of its scan until the output register is free.
// Reset clears all used flags at once, sets enable to one and the stale
// limit to 15000 ms; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module address_track_table_lru_top #(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  attl_pkg::t_in                i_in,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output attl_pkg::t_out               o_out,
    input  wire                          i_cfg_we,
    input  wire                          i_cfg_index,
    input  wire [attl_pkg::TIME_W-1:0]   i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                       r_state;
    attl_pkg::t_carry             r_head;
    attl_pkg::t_carry             r_tail;
    attl_pkg::t_out               r_out;
    logic                         r_out_valid;
    logic                         r_enable;
    logic [attl_pkg::TIME_W-1:0]  r_stale;

    attl_pkg::t_carry             w_link [0:TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0]     w_tok;
    attl_pkg::t_carry             w_init;
    attl_pkg::t_wr                w_wr;
    attl_pkg::t_out               w_res;
    logic [attl_pkg::SLOT_W-1:0]  w_target;
    logic                         w_out_free;
    logic                         w_finish;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
            r_stale  <= attl_pkg::STALE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                attl_pkg::CFG_ENABLE: r_enable <= i_cfg_data[0];
                attl_pkg::CFG_STALE:  r_stale  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Token for a newly accepted beat; a disabled observe scans as a no-op.
    always_comb begin
        w_init       = '0;
        w_init.valid = 1'b1;
        w_init.op    = attl_pkg::t_op'(i_in.operation);
        if ((w_init.op == attl_pkg::OP_OBSERVE) && !r_enable) begin
            w_init.op = attl_pkg::OP_NONE;
        end
        w_init.addr = i_in.device_address;
        w_init.rssi = i_in.signal_strength;
        w_init.now  = i_in.now_time;
        w_init.want = i_in.entry_number;
    end

    // The chain of entry cells.
    assign w_link[0] = r_head;
    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        attl_cell #(
            .CELL_INDEX (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_carry       (w_link[g]),
            .o_carry       (w_link[g+1]),
            .i_wr          (w_wr),
            .i_stale_limit (r_stale)
        );
        assign w_tok[g] = w_link[g+1].valid;
    end

    // Slot chosen by an observe: the match, else the first free, else the oldest.
    always_comb begin
        if (r_tail.hit_found) begin
            w_target = r_tail.hit_idx;
        end else if (r_tail.free_found) begin
            w_target = r_tail.free_idx;
        end else begin
            w_target = r_tail.old_idx;
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_finish   = (r_state == S_DONE) && w_out_free;

    // Write back of the observed entry, in the cycle its result is issued.
    always_comb begin
        w_wr          = '0;
        w_wr.en       = w_finish && (r_tail.op == attl_pkg::OP_OBSERVE);
        w_wr.slot     = w_target;
        w_wr.set_addr = !r_tail.hit_found;
        w_wr.addr     = r_tail.addr;
        w_wr.rssi     = r_tail.rssi;
        w_wr.now      = r_tail.now;
    end

    // Result beat from the token that left the last cell.
    always_comb begin
        w_res            = '0;
        w_res.used_count = r_tail.n;
        case (r_tail.op)
            attl_pkg::OP_OBSERVE: begin
                w_res.accepted      = 1'b1;
                w_res.found         = r_tail.hit_found;
                w_res.allocated_new = !r_tail.hit_found;
                w_res.evicted       = !r_tail.hit_found && !r_tail.free_found;
                w_res.slot          = w_target;
                if (!r_tail.hit_found && r_tail.free_found) begin
                    w_res.used_count = r_tail.n + attl_pkg::COUNT_W'(1);
                end
            end
            attl_pkg::OP_READ: begin
                if (r_tail.rd_found) begin
                    w_res.found        = 1'b1;
                    w_res.slot         = r_tail.rd_idx;
                    w_res.out_address  = r_tail.rd_addr;
                    w_res.out_strength = r_tail.rd_rssi;
                    w_res.out_time     = r_tail.rd_time;
                end
            end
            default: begin
            end
        endcase
    end

    // Sequencer: launch the token, catch it at the end, issue the result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_head.valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_head  <= w_init;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_head.valid <= 1'b0;
                    if (w_link[TABLE_ENTRIES].valid) begin
                        r_tail  <= w_link[TABLE_ENTRIES];
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_head.valid <= 1'b0;
                    r_state      <= S_IDLE;
                end
            endcase
            // The output register takes the finished beat, or empties once read.
            if (w_finish) begin
                r_out       <= w_res;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // At most one cell holds the token at any time.
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_tok, r_head.valid}))
        else $error("more than one token in the cell chain");

    // No token is in flight while the sequencer is idle.
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ((w_tok == '0) && !r_head.valid))
        else $error("token in flight while idle");

    // The write back happens only when a finished observe is issued.
    a_wr_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr.en |-> ((r_state == S_DONE) && (r_tail.op == attl_pkg::OP_OBSERVE)))
        else $error("entry written outside the finish step");

    // The used count never exceeds the table size.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.used_count <= attl_pkg::COUNT_W'(TABLE_ENTRIES)))
        else $error("used count beyond the table size");

endmodule

`default_nettype wire

>>> tb/address_track_table_lru_top_tb.sv
// ----------------------------------------------------------------------------
// address_track_table_lru_top_tb: self-checking bench for the track table
// Reports are queued by a stimulus process and offered in bursts by a
// clocked driver. Each accepted beat is run through a behavioural copy of
// the table, and every result beat is compared field by field. The stimulus
// covers directed corner cases, then random phases under several enable and
// age-limit settings. The receiver stalls at random and holds off for long
// stretches so that the table backs up.
// ----------------------------------------------------------------------------

module address_track_table_lru_top_tb;

    localparam int N_TRACKS    = 16;
    localparam int CYCLE_LIMIT = 800000;
    localparam int POOL_SIZE   = 40;

    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             in_valid  = 1'b0;
    logic                             in_ready;
    attl_pkg::t_in                    in_data   = '0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    attl_pkg::t_out                   out_beat;
    logic                             cfg_we    = 1'b0;
    logic                             cfg_index = attl_pkg::CFG_ENABLE;
    logic [attl_pkg::TIME_W-1:0]      cfg_data  = '0;

    // Reports waiting to be offered and results that the table owes us.
    attl_pkg::t_in                    reports_pending[$];
    attl_pkg::t_out                   track_results_due[$];

    // Behavioural copy of the table and of its registers.
    logic                             trk_used [N_TRACKS];
    logic [attl_pkg::ADDR_W-1:0]      trk_addr [N_TRACKS];
    logic signed [attl_pkg::RSSI_W-1:0] trk_rssi [N_TRACKS];
    logic [attl_pkg::TIME_W-1:0]      trk_seen [N_TRACKS];
    logic                             cfg_enable = 1'b1;
    logic [attl_pkg::TIME_W-1:0]      cfg_stale  = attl_pkg::STALE_RESET;

    logic [attl_pkg::ADDR_W-1:0]      addr_pool [POOL_SIZE];
    logic [attl_pkg::TIME_W-1:0]      clock_ms = '0;

    // Driver and receiver pacing.
    logic                   offering     = 1'b0;
    int                     burst_left   = 0;
    int                     gap_left     = 0;
    int                     hold_left    = 0;
    int                     next_hold_at = 300;
    int                     rx_mode      = 0;
    int                     rx_mode_left = 0;

    // Run statistics.
    int                     cycles    = 0;
    int                     n_fail    = 0;
    int                     n_items   = 0;
    int                     n_results = 0;
    int                     n_hits    = 0;
    int                     n_new     = 0;
    int                     n_evict   = 0;
    int                     n_rd_hit  = 0;
    int                     n_freed   = 0;
    int                     n_ignored = 0;

    address_track_table_lru_top #(
        .TABLE_ENTRIES(N_TRACKS)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_beat),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Applies one report to the table copy and returns the result it owes.
    function automatic attl_pkg::t_out track_update(attl_pkg::t_in it);
        attl_pkg::t_out              r;
        int                          hit;
        int                          free_i;
        int                          old_i;
        int                          n;
        int                          i;
        logic                        have_old;
        logic [attl_pkg::TIME_W-1:0] old_t;
        logic [attl_pkg::TIME_W-1:0] age;
        r        = '0;
        hit      = -1;
        free_i   = -1;
        old_i    = 0;
        n        = 0;
        have_old = 1'b0;
        old_t    = '0;
        case (attl_pkg::t_op'(it.operation))
            attl_pkg::OP_OBSERVE: begin
                if (cfg_enable) begin
                    // Look for the address, noting the first free slot and
                    // the least recently seen track along the way.
                    for (i = 0; i < N_TRACKS; i++) begin
                        if (!trk_used[i]) begin
                            if (free_i < 0) free_i = i;
                            continue;
                        end
                        if (trk_addr[i] == it.device_address) begin
                            hit = i;
                            break;
                        end
                        if (!have_old || trk_seen[i] < old_t) begin
                            have_old = 1'b1;
                            old_t    = trk_seen[i];
                            old_i    = i;
                        end
                    end
                    r.accepted = 1'b1;
                    if (hit >= 0) begin
                        r.found = 1'b1;
                        n_hits++;
                    end else begin
                        hit             = (free_i >= 0) ? free_i : old_i;
                        r.allocated_new = 1'b1;
                        r.evicted       = (free_i < 0);
                        trk_used[hit]   = 1'b1;
                        trk_addr[hit]   = it.device_address;
                        n_new++;
                        if (free_i < 0) n_evict++;
                    end
                    trk_rssi[hit] = it.signal_strength;
                    trk_seen[hit] = it.now_time;
                    r.slot        = hit[attl_pkg::SLOT_W-1:0];
                end else begin
                    n_ignored++;
                end
            end
            attl_pkg::OP_SWEEP: begin
                // Age wraps modulo 2^32; only a strictly larger age frees.
                for (i = 0; i < N_TRACKS; i++) begin
                    age = it.now_time - trk_seen[i];
                    if (trk_used[i] && age > cfg_stale) begin
                        trk_used[i] = 1'b0;
                        n_freed++;
                    end
                end
            end
            attl_pkg::OP_READ: begin
                for (i = 0; i < N_TRACKS; i++) begin
                    if (!trk_used[i]) continue;
                    if (n == int'(it.entry_number)) begin
                        r.found        = 1'b1;
                        r.slot         = i[attl_pkg::SLOT_W-1:0];
                        r.out_address  = trk_addr[i];
                        r.out_strength = trk_rssi[i];
                        r.out_time     = trk_seen[i];
                        n_rd_hit++;
                        break;
                    end
                    n++;
                end
            end
            default: ;
        endcase
        n = 0;
        for (i = 0; i < N_TRACKS; i++) begin
            if (trk_used[i]) n++;
        end
        r.used_count = n[attl_pkg::COUNT_W-1:0];
        return r;
    endfunction

    function automatic logic [attl_pkg::ADDR_W-1:0] rand_addr();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[attl_pkg::ADDR_W-1:0];
    endfunction

    task automatic check_field(string fname, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, fname, want, got);
            n_fail++;
        end
    endtask

    task automatic put(attl_pkg::t_op op, logic [attl_pkg::ADDR_W-1:0] a,
                       logic [attl_pkg::RSSI_W-1:0] s, logic [attl_pkg::TIME_W-1:0] t,
                       logic [attl_pkg::NUM_W-1:0] e);
        attl_pkg::t_in it;
        it.operation       = op;
        it.device_address  = a;
        it.signal_strength = s;
        it.now_time        = t;
        it.entry_number    = e;
        reports_pending.push_back(it);
    endtask

    // Waits until the table has nothing in flight, then lets it go quiet.
    task automatic settle();
        while (reports_pending.size() != 0 || offering || track_results_due.size() != 0)
            @(posedge clk);
        repeat (N_TRACKS + 4) @(posedge clk);
    endtask

    // The table is idle whenever this is called, so the copy changes at once.
    task automatic write_reg(logic idx, logic [attl_pkg::TIME_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == attl_pkg::CFG_ENABLE) cfg_enable = val[0];
        else cfg_stale = val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Mostly observes from a small address pool so the table fills, hits
    // and evicts; time mostly runs forward, sometimes stands still or jumps.
    task automatic gen_traffic(int count, int pool_n);
        attl_pkg::t_in it;
        int            pick;
        repeat (count) begin
            it.device_address  = rand_addr();
            it.signal_strength = attl_pkg::RSSI_W'($urandom_range(255));
            it.now_time        = $urandom;
            it.entry_number    = attl_pkg::NUM_W'($urandom_range(63));
            pick = $urandom_range(99);
            if (pick < 58) begin
                it.operation = attl_pkg::OP_OBSERVE;
                if ($urandom_range(9) != 0)
                    it.device_address = addr_pool[$urandom_range(pool_n - 1)];
                case ($urandom_range(9))
                    0: ;
                    1: clock_ms = $urandom;
                    default: clock_ms = clock_ms + $urandom_range(1, 3000);
                endcase
                it.now_time = clock_ms;
            end else if (pick < 68) begin
                it.operation = attl_pkg::OP_SWEEP;
                it.now_time  = clock_ms;
                if ($urandom_range(1) != 0) it.now_time = clock_ms + $urandom_range(20000);
            end else if (pick < 96) begin
                it.operation = attl_pkg::OP_READ;
                if ($urandom_range(3) != 0)
                    it.entry_number = attl_pkg::NUM_W'($urandom_range(N_TRACKS + 1));
            end else begin
                it.operation = attl_pkg::OP_NONE;
            end
            reports_pending.push_back(it);
        end
    endtask

    // Driver: offers queued reports in bursts separated by random gaps.
    always @(posedge clk) begin : driver
        attl_pkg::t_out due;
        if (!rst_n) begin
            in_valid <= 1'b0;
            offering = 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                due = track_update(in_data);
                track_results_due.push_back(due);
                n_items++;
            end
            if (!in_valid || in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                    offering = 1'b0;
                end else if (reports_pending.size() != 0) begin
                    in_data  <= reports_pending.pop_front();
                    in_valid <= 1'b1;
                    offering = 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 40);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    in_valid <= 1'b0;
                    offering = 1'b0;
                end
            end
        end
    end

    // Receiver: switches between free running, random stalls and a slow
    // rhythm, with two long hold-offs that back the table up.
    always @(posedge clk) begin : receiver
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (n_results >= next_hold_at) begin
                hold_left    = 400;
                next_hold_at = next_hold_at + 1000;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                if (rx_mode_left == 0) begin
                    rx_mode      = $urandom_range(2);
                    rx_mode_left = $urandom_range(20, 200);
                end else begin
                    rx_mode_left--;
                end
                case (rx_mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(99) >= 40);
                    default: out_ready <= ($urandom_range(2) == 0);
                endcase
            end
        end
    end

    // Monitor: each result beat is checked against the oldest expectation.
    always @(posedge clk) begin : monitor
        attl_pkg::t_out want;
        if (rst_n && out_valid && out_ready) begin
            n_results++;
            if (track_results_due.size() == 0) begin
                $display("%0t: result beat with nothing expected, actual %0h", $time, out_beat);
                n_fail++;
            end else begin
                want = track_results_due.pop_front();
                check_field("accepted", 64'(want.accepted), 64'(out_beat.accepted));
                check_field("found", 64'(want.found), 64'(out_beat.found));
                check_field("allocated_new", 64'(want.allocated_new),
                            64'(out_beat.allocated_new));
                check_field("evicted", 64'(want.evicted), 64'(out_beat.evicted));
                check_field("slot", 64'(want.slot), 64'(out_beat.slot));
                check_field("out_address", 64'(want.out_address), 64'(out_beat.out_address));
                check_field("out_strength", 64'(want.out_strength),
                            64'(out_beat.out_strength));
                check_field("out_time", 64'(want.out_time), 64'(out_beat.out_time));
                check_field("used_count", 64'(want.used_count), 64'(out_beat.used_count));
            end
        end
    end

    // Watchdog.
    always @(posedge clk) begin : watchdog
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycles, track_results_due.size());
            $display("FAIL address_track_table_lru_top");
            $finish;
        end
    end

    initial begin : stimulus
        int k;
        for (k = 0; k < N_TRACKS; k++) begin
            trk_used[k] = 1'b0;
            trk_addr[k] = '0;
            trk_rssi[k] = '0;
            trk_seen[k] = '0;
        end
        for (k = 0; k < POOL_SIZE; k++) addr_pool[k] = rand_addr();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at reset settings: empty table, field extremes,
        // a hit, reads past the used entries, the unused code and a sweep
        // right at the age limit followed by one just past it.
        put(attl_pkg::OP_READ, '0, 8'h00, '0, '0);
        put(attl_pkg::OP_SWEEP, '1, 8'h80, '0, '1);
        put(attl_pkg::OP_NONE, '1, 8'h7f, '1, '1);
        put(attl_pkg::OP_OBSERVE, 48'h0, 8'h80, 32'h0, '0);
        put(attl_pkg::OP_OBSERVE, '1, 8'h7f, '1, '1);
        put(attl_pkg::OP_OBSERVE, 48'h0, 8'h00, 32'd100, '0);
        put(attl_pkg::OP_OBSERVE, 48'h5555_5555_5555, 8'hff, 32'haaaa_aaaa, 6'h2a);
        put(attl_pkg::OP_OBSERVE, 48'haaaa_aaaa_aaaa, 8'h01, 32'h5555_5555, 6'h15);
        put(attl_pkg::OP_READ, '0, 8'h00, '0, 6'd0);
        put(attl_pkg::OP_READ, '0, 8'h00, '0, 6'd1);
        put(attl_pkg::OP_READ, '0, 8'h00, '0, 6'd2);
        put(attl_pkg::OP_READ, '0, 8'h00, '0, 6'd3);
        put(attl_pkg::OP_READ, '0, 8'h00, '0, 6'd4);
        put(attl_pkg::OP_READ, '1, 8'hff, '1, 6'd63);
        put(attl_pkg::OP_SWEEP, '0, 8'h00, 32'd15100, '0);
        put(attl_pkg::OP_OBSERVE, 48'h1234_5678_9abc, 8'hc0, 32'd15100, '0);
        put(attl_pkg::OP_SWEEP, '0, 8'h00, 32'd15101, '0);
        put(attl_pkg::OP_READ, '0, 8'h00, '0, 6'd0);
        put(attl_pkg::OP_READ, '0, 8'h00, '0, 6'd1);
        settle();

        // Random phases over a range of register settings.
        write_reg(attl_pkg::CFG_ENABLE, 32'd1);
        write_reg(attl_pkg::CFG_STALE, 32'd5000);
        clock_ms = $urandom;
        gen_traffic(500, 24);
        settle();
        write_reg(attl_pkg::CFG_STALE, 32'd0);
        gen_traffic(250, 12);
        settle();
        write_reg(attl_pkg::CFG_STALE, 32'hffff_ffff);
        gen_traffic(350, POOL_SIZE);
        settle();
        write_reg(attl_pkg::CFG_ENABLE, 32'd0);
        gen_traffic(100, 16);
        settle();
        write_reg(attl_pkg::CFG_ENABLE, 32'd1);
        write_reg(attl_pkg::CFG_STALE, $urandom_range(1000, 60000));
        clock_ms = 32'hffff_0000;
        gen_traffic(500, 20);
        settle();
        write_reg(attl_pkg::CFG_STALE, $urandom);
        gen_traffic(300, 16);
        settle();

        $display("Ran %0d reports: %0d new tracks (%0d by eviction), %0d updates, %0d reads hit.",
                 n_items, n_new, n_evict, n_hits, n_rd_hit);
        $display("Sweeps freed %0d tracks, %0d observes ignored while disabled, %0d mismatches.",
                 n_freed, n_ignored, n_fail);
        if (n_fail == 0 && track_results_due.size() == 0) begin
            $display("PASS address_track_table_lru_top");
        end else begin
            $display("FAIL address_track_table_lru_top");
        end
        $finish;
    end

endmodule

>>> files.f
sv/attl_pkg.sv
sv/attl_cell.sv
sv/address_track_table_lru_top.sv
tb/address_track_table_lru_top_tb.sv
